// ----- hdl/sogt_pkg.sv -----
// Shared widths and constants of the sorted grid threshold core.
package sogt_pkg;

   localparam int VALUE_BITS = 16;
   localparam int TOP_SPLITS = 50;
   localparam int GRID_SIDE  = 64;

   localparam int CELL_MAX  = GRID_SIDE * GRID_SIDE;
   localparam int CNT_W     = $clog2(CELL_MAX + 2);
   localparam int SUM_W     = $clog2(CELL_MAX) + VALUE_BITS;
   localparam int SPLIT_W   = $clog2(TOP_SPLITS + 1);
   localparam int PSUM_W    = VALUE_BITS + SPLIT_W;
   localparam int DIFF_W    = PSUM_W + CNT_W;
   localparam int DEN_W     = SPLIT_W + CNT_W;
   localparam int SQ_W      = 2 * DIFF_W;
   localparam int PROD_W    = SQ_W + DEN_W;
   localparam int MUL_Y_W   = DIFF_W;

   localparam logic [SUM_W-1:0] SUM_MAX =
      SUM_W'((64'(CELL_MAX)) * ((64'(1) << VALUE_BITS) - 64'(1)));

   typedef struct packed {
      logic                start;
      logic [PROD_W-1:0]   x;
      logic [MUL_Y_W-1:0]  y;
   } sogt_mul_req_type;

   typedef struct packed {
      logic                done;
      logic [PROD_W-1:0]   product;
   } sogt_mul_rsp_type;

endpackage

// ----- hdl/sogt_mul.sv -----
// Shift-and-add multiplier that retires one multiplier bit per cycle.
module sogt_mul import sogt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  sogt_mul_req_type req,
   output sogt_mul_rsp_type rsp
);

   logic                run_ff,  run_in;
   logic                done_ff, done_in;
   logic [PROD_W-1:0]   x_ff,    x_in;
   logic [MUL_Y_W-1:0]  y_ff,    y_in;
   logic [PROD_W-1:0]   acc_ff,  acc_in;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      if (req.start) begin
         run_in = 1'b1;
         x_in   = req.x;
         y_in   = req.y;
         acc_in = '0;
      end else if (run_ff) begin
         if (y_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            if (y_ff[0]) begin
               acc_in = acc_ff + x_ff;
            end
            x_in = x_ff << 1;
            y_in = y_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
   end

   assign rsp.done    = done_ff;
   assign rsp.product = acc_ff;

endmodule

// ----- hdl/sorted_otsu_grid_threshold_core.sv -----
// Top level: sorted insertion of cell counts and the sequenced split search.
//
// Cells are taken one per cycle while busy is low; an ordinary cell leaves busy low.
// The cell flagged last starts the split search, and busy stays high until the
// result strobe. Each split runs a step, six multiplies on one shared shift-and-add
// multiplier, each of which runs until its multiplier operand has shifted down to zero,
// and a compare; a full grid searches up to fifty splits. The result is shown for one
// cycle on rsp_valid and cannot be held off; after it the block is ready for a new grid.
module sorted_otsu_grid_threshold_core import sogt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [VALUE_BITS-1:0] req_cell_count,
   input  logic                  req_last_cell,
   output logic                  rsp_valid,
   output logic [VALUE_BITS-1:0] rsp_threshold,
   output logic                  rsp_found
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_STEP  = 3'd1;
   localparam logic [2:0] ST_ISSUE = 3'd2;
   localparam logic [2:0] ST_WAIT  = 3'd3;
   localparam logic [2:0] ST_CMP   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   localparam logic [2:0] OP_A   = 3'd0;
   localparam logic [2:0] OP_B   = 3'd1;
   localparam logic [2:0] OP_DEN = 3'd2;
   localparam logic [2:0] OP_SQ  = 3'd3;
   localparam logic [2:0] OP_LHS = 3'd4;
   localparam logic [2:0] OP_RHS = 3'd5;

   logic [2:0]            state_ff;
   logic [2:0]            op_ff;
   logic [VALUE_BITS-1:0] top_ff [TOP_SPLITS];
   logic [VALUE_BITS-1:0] top_in [TOP_SPLITS];
   logic [SUM_W-1:0]      total_ff;
   logic [CNT_W-1:0]      nz_ff;
   logic [SUM_W-1:0]      total_in;
   logic [CNT_W-1:0]      nz_in;
   logic [CNT_W-1:0]      size_ff;
   logic [CNT_W-1:0]      sizew_ff;
   logic [SPLIT_W-1:0]    w_ff;
   logic [SPLIT_W-1:0]    limit_ff;
   logic [PSUM_W-1:0]     s_ff;
   logic [VALUE_BITS-1:0] cur_ff;
   logic [DIFF_W-1:0]     a_ff;
   logic [DIFF_W-1:0]     d_ff;
   logic [DEN_W-1:0]      den_ff;
   logic [SQ_W-1:0]       dsq_ff;
   logic [PROD_W-1:0]     lhs_ff;
   logic [PROD_W-1:0]     rhs_ff;
   logic [SQ_W-1:0]       bnsq_ff;
   logic [DEN_W-1:0]      bd_ff;
   logic [VALUE_BITS-1:0] bv_ff;
   logic                  found_ff;
   logic                  accept;
   logic [TOP_SPLITS-1:0] ins;
   logic [SUM_W-1:0]      rem;
   logic [DIFF_W-1:0]     pb;
   sogt_mul_req_type      mreq;
   sogt_mul_rsp_type      mrsp;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      for (int i = 0; i < TOP_SPLITS; i++) begin
         ins[i] = top_ff[i] < req_cell_count;
      end
      for (int i = 0; i < TOP_SPLITS; i++) begin
         if (!ins[i]) begin
            top_in[i] = top_ff[i];
         end else if (i == 0) begin
            top_in[i] = req_cell_count;
         end else if (!ins[i-1]) begin
            top_in[i] = req_cell_count;
         end else begin
            top_in[i] = top_ff[i-1];
         end
      end
      nz_in    = nz_ff;
      total_in = total_ff;
      if (req_cell_count != '0) begin
         if (nz_ff < CNT_W'(CELL_MAX)) begin
            nz_in = nz_ff + 1'b1;
         end
         if ((SUM_MAX - total_ff) < SUM_W'(req_cell_count)) begin
            total_in = SUM_MAX;
         end else begin
            total_in = total_ff + SUM_W'(req_cell_count);
         end
      end
   end

   always_comb begin
      rem        = (total_ff >= SUM_W'(s_ff)) ? (total_ff - SUM_W'(s_ff)) : '0;
      mreq.start = (state_ff == ST_ISSUE);
      mreq.x     = '0;
      mreq.y     = '0;
      unique case (op_ff)
         OP_A: begin
            mreq.x = PROD_W'(s_ff);
            mreq.y = MUL_Y_W'(sizew_ff);
         end
         OP_B: begin
            mreq.x = PROD_W'(w_ff);
            mreq.y = MUL_Y_W'(rem);
         end
         OP_DEN: begin
            mreq.x = PROD_W'(w_ff);
            mreq.y = MUL_Y_W'(sizew_ff);
         end
         OP_SQ: begin
            mreq.x = PROD_W'(d_ff);
            mreq.y = d_ff;
         end
         OP_LHS: begin
            mreq.x = PROD_W'(dsq_ff);
            mreq.y = MUL_Y_W'(bd_ff);
         end
         OP_RHS: begin
            mreq.x = PROD_W'(bnsq_ff);
            mreq.y = MUL_Y_W'(den_ff);
         end
         default: begin
            mreq.x = '0;
            mreq.y = '0;
         end
      endcase
   end

   assign pb = mrsp.product[DIFF_W-1:0];

   sogt_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mreq),
      .rsp   (mrsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_A;
         total_ff <= '0;
         nz_ff    <= '0;
         found_ff <= 1'b0;
         for (int i = 0; i < TOP_SPLITS; i++) begin
            top_ff[i] <= '0;
         end
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  top_ff   <= top_in;
                  total_ff <= total_in;
                  nz_ff    <= nz_in;
                  if (req_last_cell) begin
                     size_ff  <= nz_in + 1'b1;
                     limit_ff <= (nz_in < CNT_W'(TOP_SPLITS)) ?
                                 nz_in[SPLIT_W-1:0] : SPLIT_W'(TOP_SPLITS);
                     w_ff     <= SPLIT_W'(1);
                     s_ff     <= '0;
                     bnsq_ff  <= '0;
                     bd_ff    <= DEN_W'(1);
                     bv_ff    <= '0;
                     found_ff <= 1'b0;
                     state_ff <= (nz_in == '0) ? ST_OUT : ST_STEP;
                  end
               end
            end
            ST_STEP: begin
               s_ff     <= s_ff + PSUM_W'(top_ff[0]);
               cur_ff   <= top_ff[0];
               for (int i = 0; i < TOP_SPLITS - 1; i++) begin
                  top_ff[i] <= top_ff[i+1];
               end
               top_ff[TOP_SPLITS-1] <= '0;
               sizew_ff <= size_ff - CNT_W'(w_ff);
               op_ff    <= OP_A;
               state_ff <= ST_ISSUE;
            end
            ST_ISSUE: begin
               state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               if (mrsp.done) begin
                  unique case (op_ff)
                     OP_A:    a_ff   <= pb;
                     OP_B:    d_ff   <= (a_ff >= pb) ? (a_ff - pb) : (pb - a_ff);
                     OP_DEN:  den_ff <= mrsp.product[DEN_W-1:0];
                     OP_SQ:   dsq_ff <= mrsp.product[SQ_W-1:0];
                     OP_LHS:  lhs_ff <= mrsp.product;
                     OP_RHS:  rhs_ff <= mrsp.product;
                     default: a_ff   <= a_ff;
                  endcase
                  if (op_ff == OP_RHS) begin
                     state_ff <= ST_CMP;
                  end else begin
                     op_ff    <= op_ff + 1'b1;
                     state_ff <= ST_ISSUE;
                  end
               end
            end
            ST_CMP: begin
               if (lhs_ff > rhs_ff) begin
                  bnsq_ff  <= dsq_ff;
                  bd_ff    <= den_ff;
                  bv_ff    <= cur_ff;
                  found_ff <= 1'b1;
               end
               if (w_ff == limit_ff) begin
                  state_ff <= ST_OUT;
               end else begin
                  w_ff     <= w_ff + 1'b1;
                  state_ff <= ST_STEP;
               end
            end
            ST_OUT: begin
               for (int i = 0; i < TOP_SPLITS; i++) begin
                  top_ff[i] <= '0;
               end
               total_ff <= '0;
               nz_ff    <= '0;
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = (state_ff == ST_OUT);
   assign rsp_found     = found_ff;
   assign rsp_threshold = found_ff ? bv_ff : '0;

endmodule

// ----- hdl/sogt_checker.sv -----
// Port-level checker for the sorted grid threshold core and its bind.
module sogt_checker import sogt_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  req_last_cell,
   input logic                  rsp_valid,
   input logic [VALUE_BITS-1:0] rsp_threshold,
   input logic                  rsp_found
);

   a_plain_cell_stays_ready: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_last_cell) |=> !busy)
      else $error("plain cell made the core busy");

   a_last_cell_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_last_cell) |=> busy)
      else $error("last cell did not start the search");

   a_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe outside a search");

   a_ready_after_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!busy && !rsp_valid))
      else $error("core not ready after a result");

   a_empty_threshold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_threshold == '0))
      else $error("threshold set without a split");

endmodule

bind sorted_otsu_grid_threshold_core sogt_checker u_sogt_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_last_cell (req_last_cell),
   .rsp_valid     (rsp_valid),
   .rsp_threshold (rsp_threshold),
   .rsp_found     (rsp_found)
);
